/* rtl/dilqg_pkg.sv */
// Shared types and constants for the delayed-input LQG controller.
// No dependencies; used by every module under rtl/.
package dilqg_pkg;

    // Defaults for the top-level parameters
    localparam int DEF_MAX_STATES  = 8;
    localparam int DEF_MAX_DELAYS  = 8;
    localparam int DEF_VALUE_WIDTH = 32;
    localparam int DEF_COEF_DEPTH  = 128;

    // Fixed widths: port fields and worst-case indices over the parameter ranges
    localparam int IO_W   = 32;  // width of value fields on the ports
    localparam int SLOT_W = 7;
    localparam int CA_W   = 10;  // coefficient address, covers the largest layout
    localparam int IX_W   = 6;   // loop index, covers MAX_STATES+MAX_DELAYS+1
    localparam int CFG_W  = 4;   // num_states / num_delays width

    // Item modes
    localparam logic [1:0] MODE_COEF = 2'd0;
    localparam logic [1:0] MODE_REF  = 2'd1;
    localparam logic [1:0] MODE_STEP = 2'd2;

    // Configuration register indexes
    localparam logic [1:0] REG_NUM_STATES = 2'd0;
    localparam logic [1:0] REG_NUM_DELAYS = 2'd1;
    localparam logic [1:0] REG_MAX_CTRL   = 2'd2;
    localparam logic [1:0] REG_MIN_CTRL   = 2'd3;

    // Datapath micro-operations
    typedef enum logic [3:0] {
        OP_NONE,
        OP_CLR,    // clear accumulator
        OP_READ,   // read coefficient, select second operand
        OP_MUL,    // register product
        OP_ACC,    // accumulate rounded product
        OP_EST,    // est[idx] = pred[idx] + rounded product
        OP_INNOV,  // innovation = y - acc
        OP_BOUND,  // u = clamp(acc), load output register
        OP_SHIFT,  // shift delay line, append u
        OP_PRED    // pred[idx] = acc
    } t_op;

    // Second multiplier operand
    typedef enum logic [2:0] {
        SRC_PRED,
        SRC_INNOV,
        SRC_REFEST,  // ref[ref_idx] - est[idx]
        SRC_REFDL,   // ref[ref_idx] - dl[idx]
        SRC_EST,
        SRC_DL0,
        SRC_DL1
    } t_src;

    typedef struct packed {
        t_op              op;
        t_src             src;
        logic [CA_W-1:0]  coef_addr;
        logic [IX_W-1:0]  idx;
        logic [IX_W-1:0]  ref_idx;
    } t_dp_cmd;

    typedef struct packed {
        logic out_free;  // output register can take a new item this cycle
    } t_dp_stat;

    typedef struct packed {
        logic                    we_coef;
        logic                    we_ref;
        logic                    start;
        logic [SLOT_W-1:0]       slot;
        logic signed [IO_W-1:0]  value;
        logic signed [IO_W-1:0]  meas;
    } t_load;

endpackage

/* rtl/dilqg_datapath.sv */
// Datapath: coefficient memory, state arrays, one multiply-accumulate unit.
// Depends on dilqg_pkg; driven by dilqg_ctrl through t_dp_cmd.
module dilqg_datapath #(
    parameter int MAX_STATES  = dilqg_pkg::DEF_MAX_STATES,
    parameter int MAX_DELAYS  = dilqg_pkg::DEF_MAX_DELAYS,
    parameter int VALUE_WIDTH = dilqg_pkg::DEF_VALUE_WIDTH,
    parameter int COEF_DEPTH  = dilqg_pkg::DEF_COEF_DEPTH
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  dilqg_pkg::t_dp_cmd                   i_cmd,
    input  dilqg_pkg::t_load                     i_load,
    input  logic signed [dilqg_pkg::IO_W-1:0]    i_max_ctrl,
    input  logic signed [dilqg_pkg::IO_W-1:0]    i_min_ctrl,
    input  logic [dilqg_pkg::IX_W-1:0]           i_d,
    output dilqg_pkg::t_dp_stat                  o_stat,
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output logic signed [dilqg_pkg::IO_W-1:0]    o_control
);
    localparam int W    = VALUE_WIDTH;
    localparam int BW   = (W > dilqg_pkg::IO_W) ? W : dilqg_pkg::IO_W;
    localparam int PW   = W + BW;
    localparam int XW   = PW + 2;
    localparam int AW   = W + dilqg_pkg::IX_W;
    localparam int RDEP = MAX_STATES + MAX_DELAYS + 1;
    localparam int LDEP = MAX_DELAYS + 2;
    localparam int SIW  = (MAX_STATES > 1) ? $clog2(MAX_STATES) : 1;
    localparam int RIW  = $clog2(RDEP);
    localparam int LIW  = $clog2(LDEP);
    localparam int MW   = $clog2(COEF_DEPTH);
    localparam int IXW  = dilqg_pkg::IX_W;
    localparam int CAW  = dilqg_pkg::CA_W;

    localparam logic signed [XW-1:0] W_HI = $signed({{(XW-W+1){1'b0}}, {(W-1){1'b1}}});
    localparam logic signed [XW-1:0] W_LO = ~W_HI;

    // Saturate a wide value to W bits
    function automatic logic signed [W-1:0] sat_w(input logic signed [XW-1:0] v);
        logic signed [W-1:0] r;
        if (v > W_HI)      r = W_HI[W-1:0];
        else if (v < W_LO) r = W_LO[W-1:0];
        else               r = v[W-1:0];
        return r;
    endfunction

    // Drop 16 fraction bits, round half away from zero, saturate
    function automatic logic signed [W-1:0] rnd_sat(input logic signed [PW-1:0] p);
        logic signed [XW-1:0] pe;
        logic [XW-1:0]        m;
        logic [XW-1:0]        q;
        logic signed [XW-1:0] s;
        pe = XW'(p);
        m  = pe[XW-1] ? XW'(-pe) : XW'(pe);
        q  = (m + XW'(32768)) >> 16;
        s  = pe[XW-1] ? -$signed(q) : $signed(q);
        return sat_w(s);
    endfunction

    logic signed [W-1:0]   r_mem [0:COEF_DEPTH-1];
    logic signed [W-1:0]   r_ref [0:RDEP-1];
    logic signed [W-1:0]   r_est [0:MAX_STATES-1];
    logic signed [W-1:0]   r_pred[0:MAX_STATES-1];
    logic signed [BW-1:0]  r_dl  [0:LDEP-1];

    logic signed [W-1:0]   r_coef;
    logic                  r_czero;
    logic signed [BW-1:0]  r_opb;
    logic signed [PW-1:0]  r_prod;
    logic signed [AW-1:0]  r_acc;
    logic signed [W-1:0]   r_meas;
    logic signed [W-1:0]   r_innov;
    logic signed [BW-1:0]  r_u;
    logic signed [dilqg_pkg::IO_W-1:0] r_out;
    logic                  r_out_valid;

    logic [SIW-1:0]        w_si;
    logic [RIW-1:0]        w_ri;
    logic [LIW-1:0]        w_li;
    logic signed [BW-1:0]  n_opb;
    logic signed [W-1:0]   w_term;
    logic signed [XW-1:0]  w_u_raw;
    logic signed [XW-1:0]  w_u_max;
    logic signed [XW-1:0]  w_u;
    logic [CAW-1:0]        w_slot_ext;

    assign w_si       = i_cmd.idx[SIW-1:0];
    assign w_ri       = i_cmd.ref_idx[RIW-1:0];
    assign w_li       = i_cmd.idx[LIW-1:0];
    assign w_term     = rnd_sat(r_prod);
    assign w_slot_ext = CAW'(i_load.slot);

    // Second operand select
    always_comb begin
        unique case (i_cmd.src)
            dilqg_pkg::SRC_PRED:   n_opb = BW'(r_pred[w_si]);
            dilqg_pkg::SRC_INNOV:  n_opb = BW'(r_innov);
            dilqg_pkg::SRC_REFEST: n_opb = BW'(sat_w(XW'(r_ref[w_ri]) - XW'(r_est[w_si])));
            dilqg_pkg::SRC_REFDL:  n_opb = BW'(sat_w(XW'(r_ref[w_ri]) - XW'(r_dl[w_li])));
            dilqg_pkg::SRC_EST:    n_opb = BW'(r_est[w_si]);
            dilqg_pkg::SRC_DL0:    n_opb = r_dl[0];
            dilqg_pkg::SRC_DL1:    n_opb = r_dl[1];
            default:               n_opb = '0;
        endcase
    end

    // Clamp: upper bound first, then lower
    always_comb begin
        w_u_raw = XW'(sat_w(XW'(r_acc)));
        w_u_max = (w_u_raw > XW'(i_max_ctrl)) ? XW'(i_max_ctrl) : w_u_raw;
        w_u     = (w_u_max < XW'(i_min_ctrl)) ? XW'(i_min_ctrl) : w_u_max;
    end

    // Coefficient memory: one write port, registered read
    always_ff @(posedge i_clk) begin
        if (i_load.we_coef) begin
            r_mem[w_slot_ext[MW-1:0]] <= sat_w(XW'(i_load.value));
        end
        if (i_cmd.op == dilqg_pkg::OP_READ) begin
            r_coef <= r_mem[i_cmd.coef_addr[MW-1:0]];
        end
    end

    // Operand and product stages, measurement register
    always_ff @(posedge i_clk) begin
        if (i_cmd.op == dilqg_pkg::OP_READ) begin
            r_czero <= (i_cmd.coef_addr >= CAW'(COEF_DEPTH));
            r_opb   <= n_opb;
        end
        if (i_cmd.op == dilqg_pkg::OP_MUL) begin
            r_prod <= r_czero ? '0 : PW'(r_coef) * PW'(r_opb);
        end
        if (i_load.start) begin
            r_meas <= sat_w(XW'(i_load.meas));
        end
    end

    // State arrays, accumulator and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < RDEP; k++)       r_ref[k]  <= '0;
            for (int k = 0; k < MAX_STATES; k++) r_est[k]  <= '0;
            for (int k = 0; k < MAX_STATES; k++) r_pred[k] <= '0;
            for (int k = 0; k < LDEP; k++)       r_dl[k]   <= '0;
            r_acc       <= '0;
            r_innov     <= '0;
            r_u         <= '0;
            r_out       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (i_load.we_ref) begin
                r_ref[i_load.slot[RIW-1:0]] <= sat_w(XW'(i_load.value));
            end
            unique case (i_cmd.op)
                dilqg_pkg::OP_CLR:   r_acc <= '0;
                dilqg_pkg::OP_ACC:   r_acc <= r_acc + AW'(w_term);
                dilqg_pkg::OP_EST:   r_est[w_si] <= sat_w(XW'(r_pred[w_si]) + XW'(w_term));
                dilqg_pkg::OP_INNOV: r_innov <= sat_w(XW'(r_meas) - XW'(sat_w(XW'(r_acc))));
                dilqg_pkg::OP_BOUND: begin
                    r_u         <= BW'(w_u);
                    r_out       <= w_u[dilqg_pkg::IO_W-1:0];
                    r_out_valid <= 1'b1;
                end
                dilqg_pkg::OP_SHIFT: begin
                    for (int k = 0; k < LDEP - 1; k++) begin
                        if (IXW'(k) <= i_d) r_dl[k] <= r_dl[k+1];
                    end
                    for (int k = 1; k < LDEP; k++) begin
                        if (IXW'(k) == IXW'(i_d + 1'b1)) r_dl[k] <= r_u;
                    end
                end
                dilqg_pkg::OP_PRED:  r_pred[w_si] <= sat_w(XW'(r_acc));
                default: ;
            endcase
        end
    end

    assign o_stat.out_free = !r_out_valid || !i_out_stall;
    assign o_out_valid     = r_out_valid;
    assign o_control       = r_out;

endmodule

/* rtl/dilqg_ctrl.sv */
// Step sequencer: walks correct, control, bound, shift and predict phases.
// Depends on dilqg_pkg; issues t_dp_cmd to dilqg_datapath.
module dilqg_ctrl #(
    parameter int MAX_STATES = dilqg_pkg::DEF_MAX_STATES,
    parameter int MAX_DELAYS = dilqg_pkg::DEF_MAX_DELAYS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [dilqg_pkg::IX_W-1:0]    i_n,
    input  logic [dilqg_pkg::IX_W-1:0]    i_d,
    input  dilqg_pkg::t_dp_stat           i_stat,
    output dilqg_pkg::t_dp_cmd            o_cmd,
    output logic                          o_busy
);
    localparam int CAW    = dilqg_pkg::CA_W;
    localparam int IXW    = dilqg_pkg::IX_W;
    localparam int OFS_B1 = MAX_STATES * MAX_STATES;
    localparam int OFS_B2 = OFS_B1 + MAX_STATES;
    localparam int OFS_C  = OFS_B2 + MAX_STATES;
    localparam int OFS_K  = OFS_C + MAX_STATES;
    localparam int OFS_L  = OFS_K + MAX_STATES + MAX_DELAYS + 1;

    typedef enum logic [3:0] {
        PH_IDLE, PH_CLR_C, PH_CORR, PH_INNOV, PH_GAIN, PH_CLR_K, PH_CTRL,
        PH_BOUND, PH_SHIFT, PH_CLR_P, PH_PRED, PH_PWR
    } t_phase;

    typedef enum logic [1:0] { SUB_RD, SUB_MUL, SUB_ACC } t_sub;

    t_phase          r_phase;
    t_sub            r_sub;
    logic [IXW-1:0]  r_i;
    logic [IXW-1:0]  r_j;
    logic            w_term_phase;
    logic            w_last;

    // Last term of the running dot product
    always_comb begin
        unique case (r_phase)
            PH_CORR: w_last = (r_j == IXW'(i_n - 1'b1));
            PH_GAIN: w_last = (r_i == IXW'(i_n - 1'b1));
            PH_CTRL: w_last = (r_j == IXW'(i_n + i_d));
            PH_PRED: w_last = (r_j == IXW'(i_n + 1'b1));
            default: w_last = 1'b0;
        endcase
    end

    assign w_term_phase = (r_phase == PH_CORR) || (r_phase == PH_GAIN) ||
                          (r_phase == PH_CTRL) || (r_phase == PH_PRED);

    // Command decode
    always_comb begin
        o_cmd           = '0;
        o_cmd.op        = dilqg_pkg::OP_NONE;
        o_cmd.src       = dilqg_pkg::SRC_PRED;
        o_cmd.idx       = r_j;
        o_cmd.ref_idx   = r_j;
        unique case (r_phase)
            PH_CORR: begin
                o_cmd.src       = dilqg_pkg::SRC_PRED;
                o_cmd.coef_addr = CAW'(OFS_C) + CAW'(r_j);
            end
            PH_GAIN: begin
                o_cmd.src       = dilqg_pkg::SRC_INNOV;
                o_cmd.idx       = r_i;
                o_cmd.coef_addr = CAW'(OFS_L) + CAW'(r_i);
            end
            PH_CTRL: begin
                o_cmd.coef_addr = CAW'(OFS_K) + CAW'(r_j);
                if (r_j < i_n) begin
                    o_cmd.src = dilqg_pkg::SRC_REFEST;
                end else begin
                    o_cmd.src = dilqg_pkg::SRC_REFDL;
                    o_cmd.idx = IXW'(r_j - i_n + 1'b1);
                end
            end
            PH_PRED: begin
                if (r_j < i_n) begin
                    o_cmd.src       = dilqg_pkg::SRC_EST;
                    o_cmd.coef_addr = CAW'(r_i) * CAW'(MAX_STATES) + CAW'(r_j);
                end else if (r_j == i_n) begin
                    o_cmd.src       = dilqg_pkg::SRC_DL0;
                    o_cmd.coef_addr = CAW'(OFS_B1) + CAW'(r_i);
                end else begin
                    o_cmd.src       = dilqg_pkg::SRC_DL1;
                    o_cmd.coef_addr = CAW'(OFS_B2) + CAW'(r_i);
                end
            end
            default: ;
        endcase

        if (w_term_phase) begin
            unique case (r_sub)
                SUB_RD:  o_cmd.op = dilqg_pkg::OP_READ;
                SUB_MUL: o_cmd.op = dilqg_pkg::OP_MUL;
                SUB_ACC: o_cmd.op = (r_phase == PH_GAIN) ? dilqg_pkg::OP_EST
                                                         : dilqg_pkg::OP_ACC;
                default: o_cmd.op = dilqg_pkg::OP_NONE;
            endcase
        end else begin
            unique case (r_phase)
                PH_CLR_C, PH_CLR_K, PH_CLR_P: o_cmd.op = dilqg_pkg::OP_CLR;
                PH_INNOV: o_cmd.op = dilqg_pkg::OP_INNOV;
                PH_BOUND: o_cmd.op = i_stat.out_free ? dilqg_pkg::OP_BOUND
                                                     : dilqg_pkg::OP_NONE;
                PH_SHIFT: o_cmd.op = dilqg_pkg::OP_SHIFT;
                PH_PWR: begin
                    o_cmd.op  = dilqg_pkg::OP_PRED;
                    o_cmd.idx = r_i;
                end
                default:  o_cmd.op = dilqg_pkg::OP_NONE;
            endcase
        end
    end

    // Phase, term step and loop counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_sub   <= SUB_RD;
            r_i     <= '0;
            r_j     <= '0;
        end else if (w_term_phase) begin
            unique case (r_sub)
                SUB_RD:  r_sub <= SUB_MUL;
                SUB_MUL: r_sub <= SUB_ACC;
                SUB_ACC: begin
                    r_sub <= SUB_RD;
                    if (!w_last) begin
                        if (r_phase == PH_GAIN) r_i <= r_i + 1'b1;
                        else                    r_j <= r_j + 1'b1;
                    end else begin
                        unique case (r_phase)
                            PH_CORR: r_phase <= PH_INNOV;
                            PH_GAIN: r_phase <= PH_CLR_K;
                            PH_CTRL: r_phase <= PH_BOUND;
                            default: r_phase <= PH_PWR;
                        endcase
                    end
                end
                default: r_sub <= SUB_RD;
            endcase
        end else begin
            unique case (r_phase)
                PH_IDLE: begin
                    if (i_start) r_phase <= PH_CLR_C;
                    r_j <= '0;
                end
                PH_CLR_C: r_phase <= PH_CORR;
                PH_INNOV: begin
                    r_phase <= PH_GAIN;
                    r_i     <= '0;
                end
                PH_CLR_K: begin
                    r_phase <= PH_CTRL;
                    r_j     <= '0;
                end
                PH_BOUND: if (i_stat.out_free) r_phase <= PH_SHIFT;
                PH_SHIFT: begin
                    r_phase <= PH_CLR_P;
                    r_i     <= '0;
                end
                PH_CLR_P: begin
                    r_phase <= PH_PRED;
                    r_j     <= '0;
                end
                PH_PWR: begin
                    if (r_i == IXW'(i_n - 1'b1)) begin
                        r_phase <= PH_IDLE;
                    end else begin
                        r_i     <= r_i + 1'b1;
                        r_phase <= PH_CLR_P;
                    end
                end
                default: r_phase <= PH_IDLE;
            endcase
        end
    end

    assign o_busy = (r_phase != PH_IDLE);

endmodule

/* rtl/delayed_input_lqg_controller.sv */
// Top level of the delayed-input LQG controller: config registers, item decode.
// Depends on dilqg_pkg, dilqg_ctrl and dilqg_datapath.
//
//   channel   signals                                       direction
//   input     i_in_valid, o_in_stall, i_mode, i_slot,       in
//             i_load_value, i_measurement
//   output    o_out_valid, i_out_stall, o_control           out
//   config    i_cfg_we, i_cfg_idx, i_cfg_data               in
//
// Load items (mode 0/1) and unused mode 3 are taken while idle and do not make
// the block busy. A step stalls the input until it ends; the single
// multiply-accumulate unit takes its terms one at a time (memory read, multiply,
// accumulate). A step holds in its bound phase while the previous result is still
// stalled at the output. Reset is synchronous, active low, and clears all state but
// the coefficient memory and the coefficient, operand, product and measurement registers.
module delayed_input_lqg_controller #(
    parameter int MAX_STATES  = dilqg_pkg::DEF_MAX_STATES,
    parameter int MAX_DELAYS  = dilqg_pkg::DEF_MAX_DELAYS,
    parameter int VALUE_WIDTH = dilqg_pkg::DEF_VALUE_WIDTH,
    parameter int COEF_DEPTH  = dilqg_pkg::DEF_COEF_DEPTH
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_in_valid,
    output logic                                   o_in_stall,
    input  logic [1:0]                             i_mode,
    input  logic [dilqg_pkg::SLOT_W-1:0]           i_slot,
    input  logic signed [dilqg_pkg::IO_W-1:0]      i_load_value,
    input  logic signed [dilqg_pkg::IO_W-1:0]      i_measurement,
    output logic                                   o_out_valid,
    input  logic                                   i_out_stall,
    output logic signed [dilqg_pkg::IO_W-1:0]      o_control,
    input  logic                                   i_cfg_we,
    input  logic [1:0]                             i_cfg_idx,
    input  logic [dilqg_pkg::IO_W-1:0]             i_cfg_data
);
    localparam int IXW  = dilqg_pkg::IX_W;
    localparam int CAW  = dilqg_pkg::CA_W;
    localparam int RDEP = MAX_STATES + MAX_DELAYS + 1;

    logic [dilqg_pkg::CFG_W-1:0]      r_num_states;
    logic [dilqg_pkg::CFG_W-1:0]      r_num_delays;
    logic signed [dilqg_pkg::IO_W-1:0] r_max_ctrl;
    logic signed [dilqg_pkg::IO_W-1:0] r_min_ctrl;

    logic                 w_busy;
    logic                 w_acc;
    logic [IXW-1:0]       w_n;
    logic [IXW-1:0]       w_d;
    dilqg_pkg::t_load     w_load;
    dilqg_pkg::t_dp_cmd   w_cmd;
    dilqg_pkg::t_dp_stat  w_stat;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_states <= dilqg_pkg::CFG_W'(1);
            r_num_delays <= '0;
            r_max_ctrl   <= 32'sh7FFF_FFFF;
            r_min_ctrl   <= 32'sh8000_0000;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                dilqg_pkg::REG_NUM_STATES: r_num_states <= i_cfg_data[dilqg_pkg::CFG_W-1:0];
                dilqg_pkg::REG_NUM_DELAYS: r_num_delays <= i_cfg_data[dilqg_pkg::CFG_W-1:0];
                dilqg_pkg::REG_MAX_CTRL:   r_max_ctrl   <= $signed(i_cfg_data);
                dilqg_pkg::REG_MIN_CTRL:   r_min_ctrl   <= $signed(i_cfg_data);
                default: ;
            endcase
        end
    end

    // Effective sizes: zero states acts as one, both limited to their maxima
    always_comb begin
        if (r_num_states == '0)
            w_n = IXW'(1);
        else if (IXW'(r_num_states) > IXW'(MAX_STATES))
            w_n = IXW'(MAX_STATES);
        else
            w_n = IXW'(r_num_states);
        if (IXW'(r_num_delays) > IXW'(MAX_DELAYS))
            w_d = IXW'(MAX_DELAYS);
        else
            w_d = IXW'(r_num_delays);
    end

    // Item decode
    assign o_in_stall      = w_busy;
    assign w_acc           = i_in_valid && !w_busy;
    assign w_load.we_coef  = w_acc && (i_mode == dilqg_pkg::MODE_COEF) &&
                             (CAW'(i_slot) < CAW'(COEF_DEPTH));
    assign w_load.we_ref   = w_acc && (i_mode == dilqg_pkg::MODE_REF) &&
                             (CAW'(i_slot) < CAW'(RDEP));
    assign w_load.start    = w_acc && (i_mode == dilqg_pkg::MODE_STEP);
    assign w_load.slot     = i_slot;
    assign w_load.value    = i_load_value;
    assign w_load.meas     = i_measurement;

    dilqg_ctrl #(
        .MAX_STATES (MAX_STATES),
        .MAX_DELAYS (MAX_DELAYS)
    ) u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_load.start),
        .i_n     (w_n),
        .i_d     (w_d),
        .i_stat  (w_stat),
        .o_cmd   (w_cmd),
        .o_busy  (w_busy)
    );

    dilqg_datapath #(
        .MAX_STATES  (MAX_STATES),
        .MAX_DELAYS  (MAX_DELAYS),
        .VALUE_WIDTH (VALUE_WIDTH),
        .COEF_DEPTH  (COEF_DEPTH)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .i_load      (w_load),
        .i_max_ctrl  (r_max_ctrl),
        .i_min_ctrl  (r_min_ctrl),
        .i_d         (w_d),
        .o_stat      (w_stat),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_control   (o_control)
    );

endmodule

/* tb/sv/testbench.sv */
// Testbench for delayed_input_lqg_controller: coefficient and reference loads,
// control steps under several size and clamp settings, random idling on both sides.
// Depends on dilqg_pkg and the RTL under rtl/.
`timescale 1ns / 1ps

// Scoreboard: holds its own copy of the controller state and predicts each control output
class lqg_scoreboard;
    int unsigned      n_cfg;
    int unsigned      d_cfg;
    longint           clamp_hi;
    longint           clamp_lo;
    longint           coef_mem[128];
    longint           ref_vec[17];
    longint           x_est[8];
    longint           x_pred[8];
    longint           u_line[10];
    logic signed [31:0] control_q[$];
    int               errors;
    int               checked;
    int               clamped;

    function new();
        n_cfg    = 1;
        d_cfg    = 0;
        clamp_hi = 64'sd2147483647;
        clamp_lo = -64'sd2147483648;
        foreach (coef_mem[i]) coef_mem[i] = 0;
        foreach (ref_vec[i]) ref_vec[i] = 0;
        foreach (x_est[i]) x_est[i] = 0;
        foreach (x_pred[i]) x_pred[i] = 0;
        foreach (u_line[i]) u_line[i] = 0;
        errors  = 0;
        checked = 0;
        clamped = 0;
    endfunction

    function longint sat32(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    // Q16.16 product, rounded half away from zero, saturated
    function longint qmul(longint a, longint b);
        longint p;
        longint m;
        longint q;
        p = a * b;
        m = (p < 0) ? -p : p;
        q = (m >>> 16) + ((m >>> 15) & 1);
        return sat32((p < 0) ? -q : q);
    endfunction

    function void set_reg(logic [1:0] idx, logic [31:0] data);
        case (idx)
            dilqg_pkg::REG_NUM_STATES: n_cfg = data[3:0];
            dilqg_pkg::REG_NUM_DELAYS: d_cfg = data[3:0];
            dilqg_pkg::REG_MAX_CTRL:   clamp_hi = longint'($signed(data));
            dilqg_pkg::REG_MIN_CTRL:   clamp_lo = longint'($signed(data));
            default: ;
        endcase
    endfunction

    function void note_input(logic [1:0] mode, logic [6:0] slot,
                             logic signed [31:0] val, logic signed [31:0] meas);
        int     n;
        int     d;
        longint acc;
        longint innov;
        longint u;
        longint aug[17];
        if (mode == dilqg_pkg::MODE_COEF) begin
            coef_mem[slot] = val;
            return;
        end
        if (mode == dilqg_pkg::MODE_REF) begin
            if (slot < 17) ref_vec[slot] = val;
            return;
        end
        if (mode != dilqg_pkg::MODE_STEP) return;
        n = (n_cfg < 1) ? 1 : ((n_cfg > 8) ? 8 : n_cfg);
        d = (d_cfg > 8) ? 8 : d_cfg;
        // measurement update
        acc = 0;
        for (int j = 0; j < n; j++) acc += qmul(coef_mem[80 + j], x_pred[j]);
        innov = sat32(longint'(meas) - sat32(acc));
        for (int i = 0; i < n; i++)
            x_est[i] = sat32(x_pred[i] + qmul(coef_mem[105 + i], innov));
        // control law on augmented vector
        for (int k = 0; k < n; k++) aug[k] = x_est[k];
        for (int k = 0; k <= d; k++) aug[n + k] = u_line[1 + k];
        acc = 0;
        for (int k = 0; k < n + d + 1; k++)
            acc += qmul(coef_mem[88 + k], sat32(ref_vec[k] - aug[k]));
        u = sat32(acc);
        if (u > clamp_hi) u = clamp_hi;
        if (u < clamp_lo) u = clamp_lo;
        if (u != sat32(acc)) clamped++;
        // delay line shift
        for (int k = 0; k <= d; k++) u_line[k] = u_line[k + 1];
        u_line[d + 1] = u;
        // time update
        for (int i = 0; i < n; i++) begin
            acc = 0;
            for (int j = 0; j < n; j++) acc += qmul(coef_mem[i * 8 + j], x_est[j]);
            acc += qmul(coef_mem[64 + i], u_line[0]);
            acc += qmul(coef_mem[72 + i], u_line[1]);
            x_pred[i] = sat32(acc);
        end
        control_q.push_back(u[31:0]);
    endfunction

    function void check_control(logic signed [31:0] got);
        logic signed [31:0] want;
        checked++;
        if (control_q.size() == 0) begin
            errors++;
            if (errors <= 10) $display("unexpected control item %0d", got);
            return;
        end
        want = control_q.pop_front();
        if (got !== want) begin
            errors++;
            if (errors <= 10)
                $display("control mismatch: expected %0d got %0d", want, got);
        end
    endfunction

    function int pending();
        return control_q.size();
    endfunction
endclass

module testbench;

    localparam logic [1:0] MODE_NOP = 2'd3;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_stall;
    logic [1:0]  i_mode;
    logic [6:0]  i_slot;
    logic signed [31:0] i_load_value;
    logic signed [31:0] i_measurement;
    logic        o_out_valid;
    logic        i_out_stall;
    logic signed [31:0] o_control;
    logic        i_cfg_we;
    logic [1:0]  i_cfg_idx;
    logic [31:0] i_cfg_data;

    lqg_scoreboard sb;
    int  burst_left;
    int  hold_request;
    int  steps_sent;
    int  loads_sent;

    delayed_input_lqg_controller i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall),
        .i_mode(i_mode), .i_slot(i_slot),
        .i_load_value(i_load_value), .i_measurement(i_measurement),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall), .o_control(o_control),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data)
    );

    // 12 ns clock
    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    // Q16.16 value: mostly moderate, sometimes full range or an extreme
    function automatic logic [31:0] rand_value();
        case ($urandom_range(0, 7))
            0:       return $urandom;
            1:       return 32'h7FFF_FFFF;
            2:       return 32'h8000_0000;
            default: return $urandom_range(0, 32'h0004_0000) - 32'h0002_0000;
        endcase
    endfunction

    // Coefficients kept mostly within +-1.0 so the loop stays busy
    function automatic logic [31:0] rand_coef();
        if ($urandom_range(0, 19) == 0) return $urandom;
        return $urandom_range(0, 32'h0002_0000) - 32'h0001_0000;
    endfunction

    // Offer one item with bursty gaps, wait for acceptance
    task automatic send_item(logic [1:0] mode, logic [6:0] slot,
                             logic [31:0] val, logic [31:0] meas);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 20);
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 12);
        end
        burst_left--;
        i_in_valid    <= 1'b1;
        i_mode        <= mode;
        i_slot        <= slot;
        i_load_value  <= val;
        i_measurement <= meas;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        sb.note_input(mode, slot, val, meas);
        if (mode == dilqg_pkg::MODE_STEP) steps_sent++;
        else loads_sent++;
    endtask

    task automatic random_item();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 55)
            send_item(dilqg_pkg::MODE_STEP, $urandom, $urandom, rand_value());
        else if (pick < 75)
            send_item(dilqg_pkg::MODE_COEF, $urandom, rand_coef(), $urandom);
        else if (pick < 92)
            send_item(dilqg_pkg::MODE_REF, $urandom_range(0, 20), rand_value(), $urandom);
        else
            send_item(MODE_NOP, $urandom, $urandom, $urandom);
    endtask

    // Drain until the block is idle, then write all four registers
    task automatic write_regs(logic [31:0] ns, logic [31:0] nd,
                              logic [31:0] hi, logic [31:0] lo);
        logic [31:0] vals[4];
        vals = '{ns, nd, hi, lo};
        i_in_valid <= 1'b0;
        burst_left = 0;
        while (sb.pending() > 0 || o_in_stall) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        for (int r = 0; r < 4; r++) begin
            i_cfg_we   <= 1'b1;
            i_cfg_idx  <= r[1:0];
            i_cfg_data <= vals[r];
            @(posedge i_clk);
            sb.set_reg(r[1:0], vals[r]);
        end
        i_cfg_we <= 1'b0;
    endtask

    // Output side: check accepted items, stall on its own pattern
    initial begin : out_side
        int stall_pct;
        int hold_left;
        stall_pct = 0;
        hold_left = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && !i_out_stall) sb.check_control(o_control);
            if (hold_request != 0) begin
                hold_request = 0;
                hold_left = 1500;
            end
            if ($urandom_range(0, 63) == 0) stall_pct = $urandom_range(0, 2) * 40;
            if (hold_left > 0) begin
                hold_left--;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= ($urandom_range(0, 99) < stall_pct);
            end
        end
    end

    // Main sequence
    initial begin
        sb = new();
        burst_left    = 0;
        hold_request  = 0;
        steps_sent    = 0;
        loads_sent    = 0;
        i_rst_n       = 1'b0;
        i_in_valid    = 1'b0;
        i_mode        = dilqg_pkg::MODE_COEF;
        i_slot        = '0;
        i_load_value  = '0;
        i_measurement = '0;
        i_out_stall   = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_idx     = dilqg_pkg::REG_NUM_STATES;
        i_cfg_data    = '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // fill the whole coefficient memory so nothing unwritten is read
        for (int a = 0; a < 128; a++)
            send_item(dilqg_pkg::MODE_COEF, a[6:0], rand_coef(), $urandom);

        // directed: reset sizes, extremes, ignored writes, unused mode
        send_item(dilqg_pkg::MODE_STEP, 0, 0, 32'h7FFF_FFFF);
        send_item(dilqg_pkg::MODE_STEP, 0, 0, 32'h8000_0000);
        send_item(dilqg_pkg::MODE_REF, 0, 32'h7FFF_FFFF, 0);
        send_item(dilqg_pkg::MODE_REF, 16, 32'h8000_0000, 0);
        send_item(dilqg_pkg::MODE_REF, 17, 32'h1234_5678, 0);
        send_item(dilqg_pkg::MODE_REF, 127, 32'hFFFF_FFFF, 0);
        send_item(MODE_NOP, 127, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_item(dilqg_pkg::MODE_COEF, 88, 32'h7FFF_FFFF, 0);
        send_item(dilqg_pkg::MODE_STEP, 127, 32'hFFFF_FFFF, 32'h8000_0000);
        send_item(dilqg_pkg::MODE_STEP, 0, 0, 32'h0001_0000);
        send_item(dilqg_pkg::MODE_COEF, 88, 32'h0000_8000, 0);
        send_item(dilqg_pkg::MODE_STEP, 0, 0, 32'hFFFF_0000);

        // largest sizes, then out-of-range sizes, narrow and crossed clamps
        write_regs(8, 8, 32'h7FFF_FFFF, 32'h8000_0000);
        for (int s = 0; s < 8; s++) send_item(dilqg_pkg::MODE_STEP, 0, 0, rand_value());
        write_regs(0, 15, 32'h0001_0000, 32'hFFFF_0000);
        for (int s = 0; s < 6; s++) send_item(dilqg_pkg::MODE_STEP, 0, 0, rand_value());
        write_regs(15, 9, 32'hFFFF_0000, 32'h0001_0000);
        for (int s = 0; s < 4; s++) send_item(dilqg_pkg::MODE_STEP, 0, 0, rand_value());

        // random phases with a range of settings; one long output hold
        for (int ph = 0; ph < 8; ph++) begin
            write_regs($urandom_range(1, 8), $urandom_range(0, 8),
                       ph == 3 ? 32'h0000_8000 : 32'h7FFF_FFFF,
                       ph == 3 ? 32'hFFFF_8000 : 32'h8000_0000);
            if (ph == 5) hold_request = 1;
            for (int it = 0; it < 32; it++) random_item();
        end

        i_in_valid <= 1'b0;
        while (sb.pending() > 0) @(posedge i_clk);
        repeat (400) @(posedge i_clk);
        $display("ran %0d control steps and %0d load items, %0d outputs checked, %0d clamped",
                 steps_sent, loads_sent, sb.checked, sb.clamped);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("%0d mismatches, %0d outputs missing", sb.errors, sb.pending());
            $display("== FAIL ==");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #20ms;
        $display("timeout");
        $display("== FAIL ==");
        $finish;
    end
endmodule

/* sim.f */
rtl/dilqg_pkg.sv
rtl/dilqg_datapath.sv
rtl/dilqg_ctrl.sv
rtl/delayed_input_lqg_controller.sv
tb/sv/testbench.sv
